[rtl/core/ppmfd_pkg.sv]
// Shared types and constants for the PPM frame decoder.
package ppmfd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;   // channel slot index field
    localparam int SLOT_W       = 4;   // slot counter, holds 0..MAX_CHANNELS
    localparam int TICK_W       = 16;
    localparam int GAIN_W       = 24;
    localparam int SPEED_W      = 16;
    localparam int FRAME_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int OUT_DATA_W   = 40;
    localparam int PROD_W       = TICK_W + 1 + GAIN_W;   // signed diff times unsigned gain
    localparam int SHIFT        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd3;

    localparam logic [TICK_W-1:0] SYNC_RESET = 16'd2100;
    localparam logic [TICK_W-1:0] LOW_RESET  = 16'd500;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd2097;

    // one in Q4.12
    localparam int SPEED_OFFSET = 4096;

    typedef logic [TICK_W-1:0] tick_t;

endpackage

[rtl/core/ppm_frame_decoder.sv]
// PPM frame decoder: stores channel widths, emits scaled speeds on frame sync.
// Pulse beats are taken one per cycle while the decoder is collecting; each
// stored width goes into an 8-entry synchronous width memory. A sync pulse
// that closes a frame with at least one channel starts an emission pass: the
// memory is read one slot per cycle while the output is not stalled, and
// each width runs through a two-stage scale pipeline (multiply, then shift,
// offset and saturate) to give the eight result beats of a frame. Input
// beats are held off from the sync beat until the last slot has reached the
// output register. Slots not refreshed in a frame report their previous
// width, or zero after reset. Configuration is written through
// cfg_we/cfg_index/cfg_data.
module ppm_frame_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ppmfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ppmfd_pkg::TICK_W-1:0]          s_axis_tdata,   // [15:0] pulse_ticks
    input  logic                                  s_axis_tuser,   // [0] is_period
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] channel, [18:3] speed, [22:19] channels_seen, [38:23] frame_count, [39] zero
    output logic [ppmfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    // configuration
    logic                              enable_reg;
    ppmfd_pkg::tick_t                  sync_ticks_reg;
    ppmfd_pkg::tick_t                  low_ticks_reg;
    logic [ppmfd_pkg::GAIN_W-1:0]      gain_reg;

    // control
    logic                              state_reg;
    logic [ppmfd_pkg::SLOT_W-1:0]      slot_index_reg;
    logic [ppmfd_pkg::FRAME_W-1:0]     frames_done_reg;
    logic [ppmfd_pkg::SLOT_W-1:0]      seen_reg;
    logic [ppmfd_pkg::CH_W-1:0]        rd_cnt_reg;
    logic [ppmfd_pkg::MAX_CHANNELS-1:0] valid_reg;

    // width memory
    ppmfd_pkg::tick_t                  mem [ppmfd_pkg::MAX_CHANNELS];
    ppmfd_pkg::tick_t                  rdata_reg;

    // pipeline
    logic                              s1_valid_reg;
    logic                              s1_wvalid_reg;
    logic [ppmfd_pkg::CH_W-1:0]        s1_ch_reg;
    logic                              s1_last_reg;
    logic                              s2_valid_reg;
    logic [ppmfd_pkg::CH_W-1:0]        s2_ch_reg;
    logic                              s2_last_reg;
    logic signed [ppmfd_pkg::PROD_W-1:0] prod_reg;

    logic                              out_valid_reg;
    logic [ppmfd_pkg::CH_W-1:0]        out_ch_reg;
    logic [ppmfd_pkg::SPEED_W-1:0]     out_speed_reg;
    logic [ppmfd_pkg::SLOT_W-1:0]      out_seen_reg;
    logic [ppmfd_pkg::FRAME_W-1:0]     out_frame_reg;
    logic                              out_last_reg;

    logic                              advance;
    logic                              accept;
    logic                              is_sync;
    logic                              frame_end;
    logic                              store_wr;
    logic                              issue;
    ppmfd_pkg::tick_t                  width;
    logic signed [ppmfd_pkg::TICK_W:0] diff;
    // |diff * gain| stays below 2^40, so PROD_W bits hold it exactly
    logic signed [ppmfd_pkg::PROD_W-1:0] prod_full;
    logic signed [ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT-1:0] scaled;
    logic signed [ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT:0]   offset;
    logic [ppmfd_pkg::SPEED_W-1:0]     speed_sat;

    // whole pipeline moves together; stalls when the output register is held
    assign advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !s1_valid_reg && !s2_valid_reg;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_sync   = s_axis_tdata > sync_ticks_reg;
    assign frame_end = accept && enable_reg && !s_axis_tuser && is_sync
                       && (slot_index_reg != '0);
    assign store_wr  = accept && enable_reg && !s_axis_tuser && !is_sync
                       && (slot_index_reg < ppmfd_pkg::SLOT_W'(ppmfd_pkg::MAX_CHANNELS));
    assign issue     = (state_reg == ST_EMIT) && advance;

    // no read/write overlap: writes only while collecting, reads only while emitting
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            mem[slot_index_reg[ppmfd_pkg::CH_W-1:0]] <= s_axis_tdata;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_cnt_reg];
        end
    end

    always_comb
    begin
        width     = s1_wvalid_reg ? rdata_reg : '0;
        diff      = $signed({1'b0, width}) - $signed({1'b0, low_ticks_reg});
        prod_full = diff * $signed({1'b0, gain_reg});
        // arithmetic shift gives floor division
        scaled    = (ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT)'(prod_reg >>> ppmfd_pkg::SHIFT);
        offset    = $signed({scaled[$high(scaled)], scaled})
                    - (ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT+1)'(ppmfd_pkg::SPEED_OFFSET);
        if (offset > (ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT+1)'(32767))
        begin
            speed_sat = 16'h7FFF;
        end
        else if (offset < -(ppmfd_pkg::PROD_W-ppmfd_pkg::SHIFT+1)'(32768))
        begin
            speed_sat = 16'h8000;
        end
        else
        begin
            speed_sat = offset[ppmfd_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            sync_ticks_reg  <= ppmfd_pkg::SYNC_RESET;
            low_ticks_reg   <= ppmfd_pkg::LOW_RESET;
            gain_reg        <= ppmfd_pkg::GAIN_RESET;
            state_reg       <= ST_IDLE;
            slot_index_reg  <= '0;
            frames_done_reg <= '0;
            seen_reg        <= '0;
            rd_cnt_reg      <= '0;
            valid_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ppmfd_pkg::REG_ENABLE: enable_reg     <= cfg_data[0];
                    ppmfd_pkg::REG_SYNC:   sync_ticks_reg <= cfg_data[ppmfd_pkg::TICK_W-1:0];
                    ppmfd_pkg::REG_LOW:    low_ticks_reg  <= cfg_data[ppmfd_pkg::TICK_W-1:0];
                    ppmfd_pkg::REG_GAIN:   gain_reg       <= cfg_data;
                    default: ;
                endcase
            end

            if (store_wr)
            begin
                valid_reg[slot_index_reg[ppmfd_pkg::CH_W-1:0]] <= 1'b1;
                slot_index_reg <= slot_index_reg + 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (frame_end)
                    begin
                        frames_done_reg <= frames_done_reg + 1'b1;
                        seen_reg        <= slot_index_reg;
                        slot_index_reg  <= '0;
                        rd_cnt_reg      <= '0;
                        state_reg       <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (advance)
                    begin
                        if (rd_cnt_reg == ppmfd_pkg::CH_W'(ppmfd_pkg::MAX_CHANNELS - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (advance)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_wvalid_reg <= valid_reg[rd_cnt_reg];
            s1_ch_reg     <= rd_cnt_reg;
            s1_last_reg   <= (rd_cnt_reg == ppmfd_pkg::CH_W'(ppmfd_pkg::MAX_CHANNELS - 1));
            prod_reg      <= prod_full;
            s2_ch_reg     <= s1_ch_reg;
            s2_last_reg   <= s1_last_reg;
            out_ch_reg    <= s2_ch_reg;
            out_last_reg  <= s2_last_reg;
            out_speed_reg <= speed_sat;
            out_seen_reg  <= seen_reg;
            out_frame_reg <= frames_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_frame_reg, out_seen_reg, out_speed_reg, out_ch_reg};

endmodule

[tb/sv/ppm_frame_decoder_check.sv]
// Checker for the PPM frame decoder: mirrors config, predicts speed beats, compares.
`timescale 1ns / 100ps

module ppm_frame_decoder_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ppmfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [ppmfd_pkg::TICK_W-1:0]          s_axis_tdata,   // [15:0] pulse_ticks
    input  logic                                  s_axis_tuser,   // [0] is_period
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] channel, [18:3] speed, [22:19] channels_seen, [38:23] frame_count, [39] zero
    input  logic [ppmfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                  m_axis_tlast,
    output int                                    failures,
    output int                                    pending
);

    typedef struct packed {
        logic [ppmfd_pkg::CH_W-1:0]           channel;
        logic signed [ppmfd_pkg::SPEED_W-1:0] speed;
        logic [ppmfd_pkg::SLOT_W-1:0]         seen;
        logic [ppmfd_pkg::FRAME_W-1:0]        frame;
        logic                                 last;
    } speed_beat_t;

    speed_beat_t speed_due[$];

    // local copy of decoder state and registers
    logic [ppmfd_pkg::TICK_W-1:0]  width_mem [ppmfd_pkg::MAX_CHANNELS];
    logic [ppmfd_pkg::SLOT_W-1:0]  slots_used;
    logic [ppmfd_pkg::FRAME_W-1:0] frames_closed;
    logic                          dec_enable;
    logic [ppmfd_pkg::TICK_W-1:0]  sync_lim;
    logic [ppmfd_pkg::TICK_W-1:0]  low_lvl;
    logic [ppmfd_pkg::GAIN_W-1:0]  gain_lvl;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic logic signed [ppmfd_pkg::SPEED_W-1:0] scale_speed(
        logic [ppmfd_pkg::TICK_W-1:0] w);
        longint d;
        longint q;
        d = longint'(w) - longint'(low_lvl);
        q = (d * longint'(gain_lvl)) >>> ppmfd_pkg::SHIFT;   // arithmetic shift floors
        q = q - ppmfd_pkg::SPEED_OFFSET;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[ppmfd_pkg::SPEED_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        speed_beat_t want;
        logic [ppmfd_pkg::SLOT_W-1:0] seen_now;
        if (!rst_n)
        begin
            for (int i = 0; i < ppmfd_pkg::MAX_CHANNELS; i++)
                width_mem[i] = '0;
            slots_used    = '0;
            frames_closed = '0;
            dec_enable    = 1'b0;
            sync_lim      = ppmfd_pkg::SYNC_RESET;
            low_lvl       = ppmfd_pkg::LOW_RESET;
            gain_lvl      = ppmfd_pkg::GAIN_RESET;
            speed_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppmfd_pkg::REG_ENABLE: dec_enable = cfg_data[0];
                    ppmfd_pkg::REG_SYNC:   sync_lim   = cfg_data[ppmfd_pkg::TICK_W-1:0];
                    ppmfd_pkg::REG_LOW:    low_lvl    = cfg_data[ppmfd_pkg::TICK_W-1:0];
                    ppmfd_pkg::REG_GAIN:   gain_lvl   = cfg_data[ppmfd_pkg::GAIN_W-1:0];
                    default:    ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (speed_due.size() == 0)
                begin
                    $error("unexpected output beat: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    failures++;
                end
                else
                begin
                    want = speed_due.pop_front();
                    if (m_axis_tdata[2:0] !== want.channel)
                    begin
                        $error("channel: expected %0d, got %0d",
                               want.channel, m_axis_tdata[2:0]);
                        failures++;
                    end
                    if (m_axis_tdata[18:3] !== want.speed)
                    begin
                        $error("speed: expected %0d, got %0d",
                               want.speed, $signed(m_axis_tdata[18:3]));
                        failures++;
                    end
                    if (m_axis_tdata[22:19] !== want.seen)
                    begin
                        $error("channels_seen: expected %0d, got %0d",
                               want.seen, m_axis_tdata[22:19]);
                        failures++;
                    end
                    if (m_axis_tdata[38:23] !== want.frame)
                    begin
                        $error("frame_count: expected %0d, got %0d",
                               want.frame, m_axis_tdata[38:23]);
                        failures++;
                    end
                    if (m_axis_tdata[39] !== 1'b0)
                    begin
                        $error("tdata pad: expected 0, got %b", m_axis_tdata[39]);
                        failures++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        failures++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready && dec_enable && !s_axis_tuser)
            begin
                if (s_axis_tdata > sync_lim)
                begin
                    // a sync only closes a frame that holds at least one channel
                    if (slots_used != 0)
                    begin
                        frames_closed = frames_closed + 1'b1;
                        seen_now      = slots_used;
                        slots_used    = '0;
                        for (int k = 0; k < ppmfd_pkg::MAX_CHANNELS; k++)
                        begin
                            want.channel = k[ppmfd_pkg::CH_W-1:0];
                            want.speed   = scale_speed(width_mem[k]);
                            want.seen    = seen_now;
                            want.frame   = frames_closed;
                            want.last    = (k == ppmfd_pkg::MAX_CHANNELS - 1);
                            speed_due.push_back(want);
                        end
                    end
                end
                else if (slots_used < ppmfd_pkg::MAX_CHANNELS)
                begin
                    width_mem[slots_used[ppmfd_pkg::CH_W-1:0]] = s_axis_tdata;
                    slots_used = slots_used + 1'b1;
                end
            end
        end
        pending = speed_due.size();
    end

endmodule

[tb/sv/ppm_frame_decoder_test.sv]
// Testbench top for the PPM frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ppm_frame_decoder_test;

    localparam int STUCK_LIMIT = 4000;
    localparam int PULSE_GOAL  = 300;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_we        = 1'b0;
    logic [ppmfd_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ppmfd_pkg::TICK_W-1:0]     s_axis_tdata  = '0;   // [15:0] pulse_ticks
    logic                             s_axis_tuser  = 1'b0; // [0] is_period
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [2:0] channel, [18:3] speed, [22:19] channels_seen, [38:23] frame_count, [39] zero
    logic [ppmfd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    int failures;
    int pending;
    int stuck_cycles = 0;
    int burst_left   = 0;
    bit quiet        = 1'b0;
    int sync_cur     = 2100;
    int fed          = 0;

    always #5 clk = ~clk;

    ppm_frame_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ppm_frame_decoder_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending)
    );

    // output backpressure: always ready, random ready, or a repeating 8-bit ready pattern
    int       rdy_cnt  = 0;
    int       rdy_mode = 0;
    bit [7:0] rdy_pat  = 8'hff;

    always @(negedge clk)
    begin
        if (rdy_cnt % 50 == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_pat  = 8'($urandom_range(1, 255));
        end
        case (rdy_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= rdy_pat[rdy_cnt[2:0]];
        endcase
        rdy_cnt++;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one pulse beat; a gap may open ahead of each burst
    task automatic send_pulse(input bit period, input int ticks);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = quiet ? 0 : $urandom_range(0, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= ticks[ppmfd_pkg::TICK_W-1:0];
        s_axis_tuser  <= period;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // drop valid, drain all speed beats, then let the pipeline empty
    task automatic wait_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ppmfd_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        cfg_we        <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= val[ppmfd_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we        <= 1'b0;
    endtask

    initial
    begin
        int n_ch;
        int n_frames;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        // decoder still disabled out of reset
        send_pulse(0, 1200);
        send_pulse(0, 3000);
        wait_quiet();
        write_reg(ppmfd_pkg::REG_ENABLE, 1);

        // sync with nothing stored, then period captures
        send_pulse(0, 4000);
        send_pulse(1, 1000);
        send_pulse(1, 65535);
        // short frame, width equal to threshold counts as a channel; rest stale zeros
        send_pulse(0, 0);
        send_pulse(0, 2100);
        send_pulse(0, 1500);
        send_pulse(0, 2101);
        // overfull frame: ninth width dropped
        for (int i = 0; i < 9; i++)
            send_pulse(0, 1000 + i * 125);
        send_pulse(0, 65535);

        // saturation corners
        wait_quiet();
        write_reg(ppmfd_pkg::REG_SYNC, 65535);
        write_reg(ppmfd_pkg::REG_LOW, 0);
        write_reg(ppmfd_pkg::REG_GAIN, 24'hffffff);
        send_pulse(0, 65535);
        send_pulse(0, 0);
        wait_quiet();
        write_reg(ppmfd_pkg::REG_SYNC, 0);
        send_pulse(0, 1);
        wait_quiet();
        write_reg(ppmfd_pkg::REG_LOW, 65535);
        send_pulse(0, 0);
        send_pulse(0, 65535);

        while (fed < PULSE_GOAL)
        begin
            wait_quiet();
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       sync_cur = 2100;
                1:       sync_cur = $urandom_range(1000, 3000);
                2:       sync_cur = $urandom_range(0, 65534);
                default: sync_cur = 65534;
            endcase
            write_reg(ppmfd_pkg::REG_SYNC, sync_cur);
            case ($urandom_range(0, 3))
                0:       write_reg(ppmfd_pkg::REG_LOW, 500);
                1:       write_reg(ppmfd_pkg::REG_LOW, $urandom_range(0, 65535));
                2:       write_reg(ppmfd_pkg::REG_LOW, 0);
                default: write_reg(ppmfd_pkg::REG_LOW, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(ppmfd_pkg::REG_GAIN, 2097);
                1:       write_reg(ppmfd_pkg::REG_GAIN, $urandom_range(0, 24'hffffff));
                2:       write_reg(ppmfd_pkg::REG_GAIN, 0);
                3:       write_reg(ppmfd_pkg::REG_GAIN, 24'hffffff);
                default: write_reg(ppmfd_pkg::REG_GAIN, $urandom_range(1000, 5000));
            endcase

            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(ppmfd_pkg::REG_ENABLE, 0);
                repeat ($urandom_range(2, 6))
                    send_pulse(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
                wait_quiet();
                write_reg(ppmfd_pkg::REG_ENABLE, 1);
            end

            n_frames = $urandom_range(2, 5);
            repeat (n_frames)
            begin
                n_ch = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 11)
                                                   : $urandom_range(1, 8);
                repeat (n_ch)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_pulse(1, $urandom_range(0, 65535));
                    send_pulse(0, $urandom_range(0, sync_cur));
                    fed++;
                end
                send_pulse(0, $urandom_range(sync_cur + 1, 65535));
                fed++;
                // back-to-back sync finds the store empty
                if ($urandom_range(0, 7) == 0)
                    send_pulse(0, $urandom_range(sync_cur + 1, 65535));
            end
        end

        wait_quiet();
        repeat (30) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ppmfd_pkg.sv
rtl/core/ppm_frame_decoder.sv
tb/sv/ppm_frame_decoder_check.sv
tb/sv/ppm_frame_decoder_test.sv
